[hw/rtl/ils_pkg.sv]
// Shared types and codes for the indexed list store.
// Holds the command beat, the response beat and the per-cell control group.
// No dependencies.
`default_nettype none

package ils_pkg;

   localparam int DATA_W   = 32;
   localparam int CMD_W    = 3;
   localparam int INDEX_W  = 7;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // Command codes; codes five to seven are unused and rejected as out of range.
   localparam logic [CMD_W-1:0] CMD_READ   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_HEAD   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_TAIL   = 3'd2;
   localparam logic [CMD_W-1:0] CMD_AT     = 3'd3;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd4;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]          cmd;
      logic [INDEX_W-1:0]        index;
      logic signed [DATA_W-1:0]  value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0]  read_value;
      logic                      hit;
      logic [STATUS_W-1:0]       status;
      logic [COUNT_W-1:0]        count;
   } rsp_type;

   // Broadcast to every cell of the row in the cycle a command is taken.
   typedef struct packed {
      logic ins;
      logic del;
      logic rd;
   } cell_ctrl_type;

endpackage

`default_nettype wire

[hw/rtl/ils_cell.sv]
// One storage cell of the list row: holds one element and its read pick.
// Depends on ils_pkg.
`default_nettype none

module ils_cell #(
   parameter int PW       = 7,
   parameter int CELL_POS = 0
) (
   input  wire logic                        clock,
   input  wire ils_pkg::cell_ctrl_type      ctrl,
   input  wire logic [PW-1:0]               pos,
   input  wire logic [ils_pkg::DATA_W-1:0]  value,
   input  wire logic [ils_pkg::DATA_W-1:0]  left_data,
   input  wire logic [ils_pkg::DATA_W-1:0]  right_data,
   output logic      [ils_pkg::DATA_W-1:0]  data,
   output logic      [ils_pkg::DATA_W-1:0]  pick
);
   import ils_pkg::*;

   localparam logic [PW-1:0] MY_POS = PW'(CELL_POS);

   logic [DATA_W-1:0] data_ff, data_in;
   logic [DATA_W-1:0] pick_ff, pick_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins) begin
         if (MY_POS == pos) begin
            data_in = value;
         end else if (MY_POS > pos) begin
            data_in = left_data;
         end
      end else if (ctrl.del) begin
         if (MY_POS >= pos) begin
            data_in = right_data;
         end
      end
      // Only the addressed cell puts its value on the gather tree.
      pick_in = (ctrl.rd && (MY_POS == pos)) ? data_ff : '0;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      pick_ff <= pick_in;
   end

   assign data = data_ff;
   assign pick = pick_ff;

endmodule

`default_nettype wire

[hw/rtl/ils_gather.sv]
// Two-level registered OR tree that collects the one selected cell pick.
// Depends on ils_pkg.
`default_nettype none

module ils_gather #(
   parameter int N = 64
) (
   input  wire logic                                clock,
   input  wire logic [N-1:0][ils_pkg::DATA_W-1:0]   pick,
   output logic      [ils_pkg::DATA_W-1:0]          gathered
);
   import ils_pkg::*;

   localparam int G  = 8;
   localparam int NG = (N + G - 1) / G;

   logic [NG*G-1:0][DATA_W-1:0] pad;
   logic [NG-1:0][DATA_W-1:0]   lvl_ff, lvl_in;
   logic [DATA_W-1:0]           out_ff, out_in;

   assign pad = (NG*G*DATA_W)'(pick);

   always_comb begin
      for (int g = 0; g < NG; g++) begin
         lvl_in[g] = '0;
         for (int j = 0; j < G; j++) begin
            lvl_in[g] = lvl_in[g] | pad[g*G + j];
         end
      end
      out_in = '0;
      for (int g = 0; g < NG; g++) begin
         out_in = out_in | lvl_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
      out_ff <= out_in;
   end

   assign gathered = out_ff;

endmodule

`default_nettype wire

[hw/rtl/indexed_list_store_top.sv]
// Indexed list store: a row of shifting cells holding an ordered list.
// The response strobe follows the accepting edge through the registered read
// pick in each cell and the two registered levels of the gather tree behind
// the row. A new command is not taken while the previous one is in the
// read pick or the first gather level. Insert and delete shift the whole
// row in the accepting cycle. The receiver cannot stall responses.
// Reset clears the element count and the pipeline; cell contents are undefined.
`default_nettype none

module indexed_list_store_top #(
   parameter int CAPACITY = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire ils_pkg::req_type  req_item,
   output logic                   rsp_valid,
   output ils_pkg::rsp_type       rsp_item
);
   import ils_pkg::*;

   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > INDEX_W) ? CW : INDEX_W;

   typedef struct packed {
      logic                hit;
      logic [STATUS_W-1:0] status;
      logic [COUNT_W-1:0]  count;
   } info_type;

   logic          accept;
   logic [CW-1:0] count_ff, count_in;
   logic          v1_ff, v2_ff, v3_ff;
   info_type      info1_ff, info2_ff, info3_ff, info_in;

   cell_ctrl_type ctrl;
   logic [PW-1:0] pos;
   logic [PW-1:0] idx_ext, cnt_ext, cnt_new_ext;
   logic          full;

   logic [CAPACITY-1:0][DATA_W-1:0] cell_data;
   logic [CAPACITY-1:0][DATA_W-1:0] cell_pick;
   logic [DATA_W-1:0]               gathered;

   assign accept  = start && !busy;
   assign idx_ext = PW'(req_item.index);
   assign cnt_ext = PW'(count_ff);
   assign full    = (count_ff == CW'(CAPACITY));

   always_comb begin
      ctrl           = '0;
      pos            = idx_ext;
      info_in.hit    = 1'b0;
      info_in.status = ST_RANGE;
      count_in       = count_ff;
      case (req_item.cmd)
         CMD_READ: begin
            if (idx_ext < cnt_ext) begin
               info_in.hit    = 1'b1;
               info_in.status = ST_DONE;
               ctrl.rd        = accept;
            end
         end
         CMD_HEAD, CMD_TAIL, CMD_AT: begin
            if (req_item.cmd == CMD_HEAD) begin
               pos = '0;
            end else if (req_item.cmd == CMD_TAIL) begin
               pos = cnt_ext;
            end
            // For insert at index the range check comes before the full check.
            if (pos > cnt_ext) begin
               info_in.status = ST_RANGE;
            end else if (full) begin
               info_in.status = ST_FULL;
            end else begin
               info_in.status = ST_DONE;
               ctrl.ins       = accept;
               count_in       = count_ff + CW'(1);
            end
         end
         CMD_DELETE: begin
            if (idx_ext < cnt_ext) begin
               info_in.status = ST_DONE;
               ctrl.del       = accept;
               count_in       = count_ff - CW'(1);
            end
         end
         default: begin
            info_in.status = ST_RANGE;
         end
      endcase
      cnt_new_ext   = PW'(count_in);
      info_in.count = cnt_new_ext[COUNT_W-1:0];
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_d, right_d;
      if (i == 0) begin : g_first
         assign left_d = req_item.value;
      end else begin : g_left
         assign left_d = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_d = cell_data[i];
      end else begin : g_right
         assign right_d = cell_data[i+1];
      end
      ils_cell #(
         .PW       (PW),
         .CELL_POS (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .pos        (pos),
         .value      (req_item.value),
         .left_data  (left_d),
         .right_data (right_d),
         .data       (cell_data[i]),
         .pick       (cell_pick[i])
      );
   end

   ils_gather #(
      .N (CAPACITY)
   ) u_gather (
      .clock    (clock),
      .pick     (cell_pick),
      .gathered (gathered)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         info1_ff <= info_in;
      end
      info2_ff <= info1_ff;
      info3_ff <= info2_ff;
   end

   assign busy                = v1_ff || v2_ff;
   assign rsp_valid           = v3_ff;
   assign rsp_item.read_value = info3_ff.hit ? gathered : '1;
   assign rsp_item.hit        = info3_ff.hit;
   assign rsp_item.status     = info3_ff.status;
   assign rsp_item.count      = info3_ff.count;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (accept && ctrl.ins) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("insert did not grow the list by one");

   a_delete_shrinks: assert property (@(posedge clock) disable iff (reset)
      (accept && ctrl.del) |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("delete did not shrink the list by one");

   a_hit_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.hit) |-> (rsp_item.status == ST_DONE))
      else $error("hit reported with a failing status");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy && !v2_ff))
      else $error("command overlapped one still in flight");

endmodule

`default_nettype wire
